// File: rtl/core/edit_distance_engine_core_defines.svh
// Assertion macros used by the edit distance engine core.
`ifndef EDIT_DISTANCE_ENGINE_CORE_DEFINES_SVH
`define EDIT_DISTANCE_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk outside of reset.
`define EDE_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("edit distance engine: same-cycle check failed");

// Next-cycle implication, checked on clk outside of reset.
`define EDE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("edit distance engine: next-cycle check failed");

`endif

// File: rtl/core/ede_pkg.sv
// Package with command codes and sequencer states of the edit distance engine.
package ede_pkg;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_QUERY  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_SWEEP = 2'd1,
		ST_EMIT  = 2'd2
	} state_t;

	localparam int unsigned DIST_W = 6;
	localparam int unsigned DIST_MAX = 63;

endpackage

// File: rtl/core/ede_cell.sv
// Shared cell unit: one Levenshtein cell from its above, left and diagonal neighbors.
module ede_cell #(
	parameter int unsigned LW = 6
) (
	input  logic [LW-1:0] above,
	input  logic [LW-1:0] left,
	input  logic [LW-1:0] diag,
	input  logic          match,
	output logic [LW-1:0] cost
);

	logic [LW-1:0] min_al;
	logic [LW-1:0] min_all;

	// take the cheapest edit, or the diagonal unchanged on a match
	always_comb begin
		min_al  = (above < left) ? above : left;
		min_all = (min_al < diag) ? min_al : diag;
		cost    = match ? diag : (min_all + LW'(1));
	end

endmodule

// File: rtl/core/edit_distance_engine_core.sv
// Edit distance engine: clear, append and query commands with a one-cell-per-cycle row sweep.
// Clear, append, ignored, dropped and empty-reference query words need no row sweep.
// Any other query word is issued, then swept one row cell per cycle through the row memory
// read port, then finished; a last query word then loads the result once the output is free.
// Reset (arst_n low, asynchronous) clears lengths, flag, sequencer and output valid;
// memories are not cleared, the row reads as 0..n while the query is empty.
module edit_distance_engine_core #(
	parameter int unsigned MAX_LEN = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] character
	input  logic [1:0] s_tuser,   // [1:0] command
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [5:0] distance, [7:6] zero
	output logic [0:0] m_tuser    // [0] overflow
);

	import ede_pkg::*;

	localparam int unsigned LW = $clog2(MAX_LEN + 1);
	localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int unsigned DW = (LW > DIST_W) ? LW : DIST_W;

	// memories
	logic [7:0]    ref_mem [MAX_LEN];
	logic [LW-1:0] row_mem [MAX_LEN+1];
	logic [7:0]    ref_rdata_q;
	logic [LW-1:0] row_rdata_q;

	// control state
	state_t        state_q, state_d;
	logic [LW-1:0] ref_len_q;
	logic [LW-1:0] qry_len_q;
	logic          dropped_q;
	logic [LW-1:0] last_cell_q;
	logic [LW-1:0] rd_j_q;
	logic          rd_busy_q;
	logic          v_s1;
	logic [LW-1:0] j_s1;
	logic          m_valid_q;
	logic [DIST_W-1:0] m_dist_q;
	logic          m_ovf_q;

	// word payload held over the sweep
	logic [7:0]    ch_q;
	logic          lastf_q;
	logic [LW-1:0] diag_q;
	logic [LW-1:0] left_q;

	// combinational control
	cmd_t          cmd;
	logic          acc;
	logic          ref_full;
	logic          qry_full;
	logic          issue;
	logic          sweep_done;
	logic          out_free;
	logic          emit_load;
	logic          row_we;
	logic [LW-1:0] row_waddr;
	logic [LW-1:0] row_wdata;
	logic [LW-1:0] above;
	logic [LW-1:0] cost;
	logic [AW-1:0] ref_raddr;
	logic [LW-1:0] ref_raddr_full;
	logic [DW-1:0] dist_ext;
	logic [DIST_W-1:0] dist_sat;

	assign cmd      = cmd_t'(s_tuser);
	assign acc      = s_tvalid && s_tready;
	assign ref_full = (ref_len_q == LW'(MAX_LEN));
	assign qry_full = (qry_len_q == LW'(MAX_LEN));
	assign out_free = !m_valid_q || m_tready;

	// sweep address and neighbor selection
	assign ref_raddr_full = rd_j_q - LW'(1);
	assign ref_raddr      = ref_raddr_full[AW-1:0];
	assign above          = (qry_len_q == '0) ? j_s1 : row_rdata_q;
	assign sweep_done     = v_s1 && (j_s1 == ref_len_q);

	ede_cell #(
		.LW (LW)
	) u_cell (
		.above (above),
		.left  (left_q),
		.diag  (diag_q),
		.match (ref_rdata_q == ch_q),
		.cost  (cost)
	);

	// saturate the reported distance
	always_comb begin
		dist_ext = DW'(last_cell_q);
		dist_sat = (dist_ext > DW'(DIST_MAX)) ? DIST_W'(DIST_MAX) : dist_ext[DIST_W-1:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && (cmd == CMD_QUERY)) begin
					if (!qry_full && (ref_len_q != '0)) begin
						state_d = ST_SWEEP;
					end else if (s_tlast) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_SWEEP: begin
				if (sweep_done) begin
					state_d = lastf_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready  = 1'b0;
		issue     = 1'b0;
		emit_load = 1'b0;
		row_we    = 1'b0;
		row_waddr = '0;
		row_wdata = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (acc && (cmd == CMD_QUERY) && !qry_full) begin
					row_we    = 1'b1;
					row_wdata = qry_len_q + LW'(1);
				end
			end
			ST_SWEEP: begin
				issue     = rd_busy_q;
				row_we    = v_s1;
				row_waddr = j_s1;
				row_wdata = cost;
			end
			ST_EMIT: begin
				emit_load = out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// write and read the memories
	always_ff @(posedge clk) begin
		if (acc && (cmd == CMD_APPEND) && !ref_full) begin
			ref_mem[ref_len_q[AW-1:0]] <= s_tdata;
		end
		if (row_we) begin
			row_mem[row_waddr] <= row_wdata;
		end
		ref_rdata_q <= ref_mem[ref_raddr];
		row_rdata_q <= row_mem[rd_j_q];
	end

	// hold the query word and advance the neighbor registers
	always_ff @(posedge clk) begin
		if (acc && (cmd == CMD_QUERY)) begin
			lastf_q <= s_tlast;
			if (!qry_full) begin
				ch_q   <= s_tdata;
				diag_q <= qry_len_q;
				left_q <= qry_len_q + LW'(1);
			end
		end
		if (state_q == ST_SWEEP && v_s1) begin
			diag_q <= above;
			left_q <= cost;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ref_len_q   <= '0;
			qry_len_q   <= '0;
			dropped_q   <= 1'b0;
			last_cell_q <= '0;
			rd_j_q      <= '0;
			rd_busy_q   <= 1'b0;
			v_s1        <= 1'b0;
			j_s1        <= '0;
			m_valid_q   <= 1'b0;
			m_dist_q    <= '0;
			m_ovf_q     <= 1'b0;
		end else begin
			state_q <= state_d;

			// decode accepted words
			if (acc) begin
				case (cmd)
					CMD_CLEAR: begin
						ref_len_q   <= '0;
						qry_len_q   <= '0;
						dropped_q   <= 1'b0;
						last_cell_q <= '0;
					end
					CMD_APPEND: begin
						qry_len_q <= '0;
						if (!ref_full) begin
							ref_len_q   <= ref_len_q + LW'(1);
							last_cell_q <= ref_len_q + LW'(1);
						end else begin
							dropped_q   <= 1'b1;
							last_cell_q <= ref_len_q;
						end
					end
					CMD_QUERY: begin
						if (qry_full) begin
							dropped_q <= 1'b1;
						end else if (ref_len_q == '0) begin
							last_cell_q <= qry_len_q + LW'(1);
							qry_len_q   <= qry_len_q + LW'(1);
						end else begin
							rd_j_q    <= LW'(1);
							rd_busy_q <= 1'b1;
						end
					end
					default: begin
						dropped_q <= dropped_q;
					end
				endcase
			end

			// issue row reads, one cell a cycle
			if (issue) begin
				if (rd_j_q == ref_len_q) begin
					rd_busy_q <= 1'b0;
				end else begin
					rd_j_q <= rd_j_q + LW'(1);
				end
			end
			v_s1 <= issue;
			j_s1 <= rd_j_q;

			// finish the row
			if (state_q == ST_SWEEP && sweep_done) begin
				last_cell_q <= cost;
				qry_len_q   <= qry_len_q + LW'(1);
			end

			// load the result word and restart the query
			if (emit_load) begin
				m_valid_q   <= 1'b1;
				m_dist_q    <= dist_sat;
				m_ovf_q     <= dropped_q;
				qry_len_q   <= '0;
				last_cell_q <= ref_len_q;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = {{(8 - DIST_W){1'b0}}, m_dist_q};
	assign m_tuser[0] = m_ovf_q;

	`include "edit_distance_engine_core_defines.svh"

	`EDE_ASSERT_SAME(a_no_cell_outside_sweep, (state_q != ST_SWEEP), !v_s1)
	`EDE_ASSERT_SAME(a_ref_len_bound, 1'b1, (ref_len_q <= LW'(MAX_LEN)))
	`EDE_ASSERT_SAME(a_qry_len_bound, 1'b1, (qry_len_q <= LW'(MAX_LEN)))
	`EDE_ASSERT_NEXT(a_emit_shows_result, emit_load, (m_valid_q && (qry_len_q == '0)))

endmodule
